// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the calibration trigger.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/co2bct_pkg.sv -----
// ----------------------------------------------------------------------------
// co2bct_pkg
// Types, constants and register indexes of the CO2 baseline calibration trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package co2bct_pkg;

  localparam int unsigned WindowDef   = 30;
  localparam int unsigned ShortLagDef = 6;

  localparam int unsigned PpmW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DiffW    = 17;
  localparam int unsigned CountW   = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CountW-1:0] ReadMax = '1;

  localparam logic [PpmW-1:0]         PlausibleMaxRst = 16'd1400;
  localparam logic [CountW-1:0]       StartupReadsRst = 6'd4;
  localparam logic [PpmW-1:0]         AboveLevelRst   = 16'd400;
  localparam logic [PpmW-1:0]         BelowLevelRst   = 16'd500;
  localparam logic [TimeW-1:0]        QuietTimeRst    = 32'd600000;
  localparam logic signed [DiffW-1:0] DropStepRst     = -17'sd15;
  localparam logic signed [DiffW-1:0] BigDropRst      = -17'sd400;
  localparam logic [TimeW-1:0]        CleanTimeRst    = 32'd14400000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPlausibleMax = 3'd0,
    CfgStartupReads = 3'd1,
    CfgAboveLevel   = 3'd2,
    CfgBelowLevel   = 3'd3,
    CfgQuietTime    = 3'd4,
    CfgDropStep     = 3'd5,
    CfgBigDrop      = 3'd6,
    CfgCleanTime    = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- hw/rtl/co2_baseline_calibration_trigger.sv -----
// ----------------------------------------------------------------------------
// co2_baseline_calibration_trigger
// Screens CO2 readings, keeps a sample ring and raises calibration requests.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   reading_ppm_i, now_ms_i
//   out       output     out_valid_o / out_ready_i accepted_o, calibrate_quiet_o,
//                                                  calibrate_drop_o, window_diff_o,
//                                                  short_diff_o
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per cycle is taken unless the output is stalled; results pass through
// the first-stage and output registers. The first stage checks the reading, writes
// the ring RAM and reads two of its entries; the second forms the differences from
// the registered read data. The ring is empty right after reset through per-entry
// valid bits. A stalled output holds the output register; one more item may wait
// in the first stage, and then input stops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_baseline_calibration_trigger #(
  parameter int unsigned WINDOW    = co2bct_pkg::WindowDef,
  parameter int unsigned SHORT_LAG = co2bct_pkg::ShortLagDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [co2bct_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [co2bct_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [co2bct_pkg::PpmW-1:0]            reading_ppm_i,
  input  wire logic [co2bct_pkg::TimeW-1:0]           now_ms_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        accepted_o,
  output logic                                        calibrate_quiet_o,
  output logic                                        calibrate_drop_o,
  output logic signed [co2bct_pkg::DiffW-1:0]         window_diff_o,
  output logic signed [co2bct_pkg::DiffW-1:0]         short_diff_o
);

  import co2bct_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AddrW  = $clog2(WINDOW);
  localparam int unsigned RunW   = $clog2(WINDOW + 1);
  localparam int unsigned LagMod = SHORT_LAG % WINDOW;
  localparam bit          LagSelf = (LagMod == 0);

  localparam logic [AddrW-1:0]  LastPos   = AddrW'(WINDOW - 1);
  localparam logic [AddrW-1:0]  LagStep   = AddrW'(LagMod);
  localparam logic [AddrW-1:0]  LagWrap   = AddrW'(WINDOW - LagMod);
  localparam logic [CountW-1:0] WindowCnt = CountW'(WINDOW);
  localparam logic [CountW-1:0] LagCnt    = CountW'(SHORT_LAG);
  localparam logic [RunW-1:0]   RunMax    = RunW'(WINDOW);

  // Configuration registers.
  logic [PpmW-1:0]         plausible_max_q;
  logic [CountW-1:0]       startup_reads_q;
  logic [PpmW-1:0]         above_level_q;
  logic [PpmW-1:0]         below_level_q;
  logic [TimeW-1:0]        quiet_time_q;
  logic signed [DiffW-1:0] drop_step_q;
  logic signed [DiffW-1:0] big_drop_q;
  logic [TimeW-1:0]        clean_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plausible_max_q <= PlausibleMaxRst;
      startup_reads_q <= StartupReadsRst;
      above_level_q   <= AboveLevelRst;
      below_level_q   <= BelowLevelRst;
      quiet_time_q    <= QuietTimeRst;
      drop_step_q     <= DropStepRst;
      big_drop_q      <= BigDropRst;
      clean_time_q    <= CleanTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPlausibleMax: plausible_max_q <= cfg_data_i[PpmW-1:0];
        CfgStartupReads: startup_reads_q <= cfg_data_i[CountW-1:0];
        CfgAboveLevel:   above_level_q   <= cfg_data_i[PpmW-1:0];
        CfgBelowLevel:   below_level_q   <= cfg_data_i[PpmW-1:0];
        CfgQuietTime:    quiet_time_q    <= cfg_data_i[TimeW-1:0];
        CfgDropStep:     drop_step_q     <= $signed(cfg_data_i[DiffW-1:0]);
        CfgBigDrop:      big_drop_q      <= $signed(cfg_data_i[DiffW-1:0]);
        CfgCleanTime:    clean_time_q    <= cfg_data_i[TimeW-1:0];
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_q, s1_d;
  logic s1_adv;
  logic in_fire;
  logic out_valid_q;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_d       = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_q);

  // First stage: screening, timestamps and ring access.
  logic [CountW-1:0] read_total_q, read_total_d;
  logic [AddrW-1:0]  ring_pos_q, ring_pos_d;
  logic [TimeW-1:0]  last_above_q, last_above_d;
  logic [TimeW-1:0]  last_below_q, last_below_d;
  logic [WINDOW-1:0] ring_vld_q, ring_vld_d;
  logic [AddrW-1:0]  old_addr;
  logic [AddrW-1:0]  lag_addr;
  logic              reading_ok;

  assign read_total_d = (read_total_q == ReadMax) ? read_total_q : read_total_q + 1'b1;
  assign reading_ok   = (reading_ppm_i != '0) &&
                        !((read_total_d <= startup_reads_q) &&
                          (reading_ppm_i > plausible_max_q));
  assign old_addr     = (ring_pos_q == LastPos) ? '0 : ring_pos_q + 1'b1;
  assign lag_addr     = (ring_pos_q >= LagStep) ? ring_pos_q - LagStep
                                                : ring_pos_q + LagWrap;

  always_comb begin
    ring_pos_d   = ring_pos_q;
    last_above_d = last_above_q;
    last_below_d = last_below_q;
    ring_vld_d   = ring_vld_q;
    if (in_fire && reading_ok) begin
      ring_pos_d = old_addr;
      ring_vld_d[ring_pos_q] = 1'b1;
      if (reading_ppm_i > above_level_q) begin
        last_above_d = now_ms_i;
      end
      if (reading_ppm_i < below_level_q) begin
        last_below_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_total_q <= '0;
      ring_pos_q   <= '0;
      last_above_q <= '0;
      last_below_q <= '0;
      ring_vld_q   <= '0;
      s1_q         <= 1'b0;
    end else begin
      if (in_fire) begin
        read_total_q <= read_total_d;
      end
      ring_pos_q   <= ring_pos_d;
      last_above_q <= last_above_d;
      last_below_q <= last_below_d;
      ring_vld_q   <= ring_vld_d;
      s1_q         <= s1_d;
    end
  end

  logic [PpmW-1:0] old_rdata;
  logic [PpmW-1:0] lag_rdata;

  co2bct_ram #(
    .Width (PpmW),
    .Depth (WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (in_fire && reading_ok),
    .waddr_i   (ring_pos_q),
    .wdata_i   (reading_ppm_i),
    .re_i      (in_fire),
    .raddr_a_i (old_addr),
    .raddr_b_i (lag_addr),
    .rdata_a_o (old_rdata),
    .rdata_b_o (lag_rdata)
  );

  // Second stage payload, loaded with each accepted item.
  logic            s1_ok_q;
  logic [PpmW-1:0] s1_reading_q;
  logic [TimeW-1:0] s1_now_q;
  logic            s1_win_en_q;
  logic            s1_lag_en_q;
  logic            s1_old_vld_q;
  logic            s1_lag_vld_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ok_q      <= reading_ok;
      s1_reading_q <= reading_ppm_i;
      s1_now_q     <= now_ms_i;
      s1_win_en_q  <= read_total_d >= WindowCnt;
      s1_lag_en_q  <= read_total_d > LagCnt;
      s1_old_vld_q <= ring_vld_q[old_addr];
      s1_lag_vld_q <= ring_vld_q[lag_addr];
    end
  end

  // Second stage: differences, drop run and calibration flags.
  logic [RunW-1:0]         drop_run_q, drop_run_d;
  logic [PpmW-1:0]         old_val;
  logic [PpmW-1:0]         lag_val;
  logic signed [DiffW-1:0] win_diff;
  logic signed [DiffW-1:0] lag_diff;
  logic                    quiet;
  logic                    drop;

  assign old_val  = s1_old_vld_q ? old_rdata : '0;
  assign lag_val  = LagSelf ? s1_reading_q : (s1_lag_vld_q ? lag_rdata : '0);
  assign win_diff = s1_win_en_q ? $signed({1'b0, s1_reading_q} - {1'b0, old_val}) : '0;
  assign lag_diff = s1_lag_en_q ? $signed({1'b0, s1_reading_q} - {1'b0, lag_val}) : '0;
  assign quiet    = (s1_now_q - last_above_q) > quiet_time_q;

  always_comb begin
    drop_run_d = drop_run_q;
    if (s1_ok_q && s1_lag_en_q) begin
      if (lag_diff < drop_step_q) begin
        if (drop_run_q < RunMax) begin
          drop_run_d = drop_run_q + 1'b1;
        end
      end else begin
        drop_run_d = '0;
      end
    end
  end

  assign drop = s1_lag_en_q && (drop_run_d >= RunMax) && (win_diff < big_drop_q) &&
                ((s1_now_q - last_below_q) > clean_time_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_run_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_q;
      if (s1_q) begin
        drop_run_q <= drop_run_d;
      end
    end
  end

  // Output register.
  logic                    accepted_q;
  logic                    cal_quiet_q;
  logic                    cal_drop_q;
  logic signed [DiffW-1:0] window_diff_q;
  logic signed [DiffW-1:0] short_diff_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q) begin
      accepted_q    <= s1_ok_q;
      cal_quiet_q   <= s1_ok_q && quiet;
      cal_drop_q    <= s1_ok_q && drop;
      window_diff_q <= s1_ok_q ? win_diff : '0;
      short_diff_q  <= s1_ok_q ? lag_diff : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign calibrate_quiet_o = cal_quiet_q;
  assign calibrate_drop_o  = cal_drop_q;
  assign window_diff_o     = window_diff_q;
  assign short_diff_o      = short_diff_q;

  logic out_zero;

  assign out_zero = !calibrate_quiet_o && !calibrate_drop_o && (window_diff_o == '0) &&
                    (short_diff_o == '0);

  `ASSERT_CLK(a_stall_holds_stage, s1_q && !s1_adv |=> s1_q, "Stalled item left stage.")
  `ASSERT_CLK(a_accept_fills_stage, in_fire |=> s1_q, "Accepted item did not reach stage.")
  `ASSERT_CLK(a_run_bounded, drop_run_q <= RunMax, "Drop run exceeds the window.")
  `ASSERT_CLK(a_pos_bounded, ring_pos_q <= LastPos, "Ring position out of range.")
  `ASSERT_CLK(a_reject_clean, out_valid_o && !accepted_o |-> out_zero, "Rejected item not zero.")

endmodule

`default_nettype wire

// ----- hw/rtl/co2bct_ram.sv -----
// ----------------------------------------------------------------------------
// co2bct_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module co2bct_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- tb/co2_baseline_calibration_trigger_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// co2_baseline_calibration_trigger_test
// Drives CO2 readings through the calibration trigger under random input gaps
// and output stalls, predicts every result in a tracker class, and checks the
// results field by field across several register settings.
// ----------------------------------------------------------------------------

module co2_baseline_calibration_trigger_test;
  import co2bct_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  typedef struct {
    logic [PpmW-1:0]         plausible_max;
    logic [CountW-1:0]       startup_reads;
    logic [PpmW-1:0]         above_level;
    logic [PpmW-1:0]         below_level;
    logic [TimeW-1:0]        quiet_ms;
    logic signed [DiffW-1:0] drop_step;
    logic signed [DiffW-1:0] big_drop;
    logic [TimeW-1:0]        clean_ms;
  } calib_cfg_t;

  typedef struct {
    logic                    accepted;
    logic                    quiet;
    logic                    drop;
    logic signed [DiffW-1:0] window_diff;
    logic signed [DiffW-1:0] short_diff;
  } calib_result_t;

  class calib_tracker;
    calib_cfg_t      cfg;
    logic [CountW-1:0] read_count;
    logic [4:0]      slot;
    logic [PpmW-1:0] ring [WindowDef];
    logic [TimeW-1:0] above_stamp;
    logic [TimeW-1:0] below_stamp;
    logic [CountW-1:0] drop_count;
    calib_result_t   awaited [$];
    int unsigned     faults;
    int unsigned     results_seen;
    int unsigned     stored;
    int unsigned     quiet_hits;
    int unsigned     drop_hits;

    function new();
      cfg.plausible_max = PlausibleMaxRst;
      cfg.startup_reads = StartupReadsRst;
      cfg.above_level   = AboveLevelRst;
      cfg.below_level   = BelowLevelRst;
      cfg.quiet_ms      = QuietTimeRst;
      cfg.drop_step     = DropStepRst;
      cfg.big_drop      = BigDropRst;
      cfg.clean_ms      = CleanTimeRst;
      read_count  = '0;
      slot        = '0;
      above_stamp = '0;
      below_stamp = '0;
      drop_count  = '0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void note_reading(logic [PpmW-1:0] ppm, logic [TimeW-1:0] stamp);
      calib_result_t exp;
      int unsigned pos, oldest, lagged;
      logic [TimeW-1:0] span;
      exp.accepted    = 1'b0;
      exp.quiet       = 1'b0;
      exp.drop        = 1'b0;
      exp.window_diff = '0;
      exp.short_diff  = '0;
      if (read_count != ReadMax) read_count++;
      if (ppm == '0 || (read_count <= cfg.startup_reads && ppm > cfg.plausible_max)) begin
        awaited.push_back(exp);
        return;
      end
      if (ppm > cfg.above_level) above_stamp = stamp;
      if (ppm < cfg.below_level) below_stamp = stamp;
      span = stamp - above_stamp;
      exp.quiet = (span > cfg.quiet_ms);
      pos = slot;
      ring[pos] = ppm;
      if (read_count >= WindowDef) begin
        oldest = (pos + 1) % WindowDef;
        exp.window_diff = $signed({1'b0, ring[pos]}) - $signed({1'b0, ring[oldest]});
      end
      if (read_count > ShortLagDef) begin
        lagged = (pos + WindowDef - (ShortLagDef % WindowDef)) % WindowDef;
        exp.short_diff = $signed({1'b0, ring[pos]}) - $signed({1'b0, ring[lagged]});
        if (exp.short_diff < cfg.drop_step) begin
          if (drop_count < WindowDef) drop_count++;
        end else begin
          drop_count = '0;
        end
        span = stamp - below_stamp;
        exp.drop = (drop_count >= WindowDef) && (exp.window_diff < cfg.big_drop) &&
                   (span > cfg.clean_ms);
      end
      slot = (pos + 1 >= WindowDef) ? '0 : 5'(pos + 1);
      exp.accepted = 1'b1;
      stored++;
      if (exp.quiet) quiet_hits++;
      if (exp.drop) drop_hits++;
      awaited.push_back(exp);
    endfunction

    function void check_result(calib_result_t got);
      calib_result_t exp;
      results_seen++;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= ReportMax)
          $display("Result %0d arrived with nothing expected", results_seen);
        return;
      end
      exp = awaited.pop_front();
      if (got.accepted !== exp.accepted || got.quiet !== exp.quiet ||
          got.drop !== exp.drop || got.window_diff !== exp.window_diff ||
          got.short_diff !== exp.short_diff) begin
        faults++;
        if (faults <= ReportMax) begin
          $display("Result %0d: expected acc=%0b quiet=%0b drop=%0b wdiff=%0d sdiff=%0d",
                   results_seen, exp.accepted, exp.quiet, exp.drop, exp.window_diff,
                   exp.short_diff);
          $display("  got acc=%0b quiet=%0b drop=%0b wdiff=%0d sdiff=%0d",
                   got.accepted, got.quiet, got.drop, got.window_diff, got.short_diff);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PpmW-1:0] reading_ppm = '0;
  logic [TimeW-1:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic calibrate_quiet;
  logic calibrate_drop;
  logic signed [DiffW-1:0] window_diff;
  logic signed [DiffW-1:0] short_diff;

  calib_tracker tracker = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  int unsigned ready_pct = 100;
  int unsigned ready_left = 0;
  logic [TimeW-1:0] clock_ms = '0;

  co2_baseline_calibration_trigger u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .reading_ppm_i     (reading_ppm),
    .now_ms_i          (now_ms),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .accepted_o        (accepted),
    .calibrate_quiet_o (calibrate_quiet),
    .calibrate_drop_o  (calibrate_drop),
    .window_diff_o     (window_diff),
    .short_diff_o      (short_diff)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 50;
        2: ready_pct = 20;
        default: ready_pct = 85;
      endcase
      ready_left <= $urandom_range(20, 120);
    end else begin
      ready_left <= ready_left - 1;
    end
    out_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk_i) begin
    calib_result_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.accepted    = accepted;
      got.quiet       = calibrate_quiet;
      got.drop        = calibrate_drop;
      got.window_diff = window_diff;
      got.short_diff  = short_diff;
      tracker.check_result(got);
    end
  end

  function automatic logic [TimeW-1:0] tick();
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(5000, 120000);
    return clock_ms;
  endfunction

  task automatic send_item(input logic [PpmW-1:0] ppm, input logic [TimeW-1:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid    <= 1'b1;
    reading_ppm <= ppm;
    now_ms      <= stamp;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_reading(ppm, stamp);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic program_config(input calib_cfg_t c);
    wait_drain();
    put_reg(CfgPlausibleMax, CfgDataW'(c.plausible_max));
    put_reg(CfgStartupReads, CfgDataW'(c.startup_reads));
    put_reg(CfgAboveLevel, CfgDataW'(c.above_level));
    put_reg(CfgBelowLevel, CfgDataW'(c.below_level));
    put_reg(CfgQuietTime, c.quiet_ms);
    put_reg(CfgDropStep, {{(CfgDataW-DiffW){c.drop_step[DiffW-1]}}, c.drop_step});
    put_reg(CfgBigDrop, {{(CfgDataW-DiffW){c.big_drop[DiffW-1]}}, c.big_drop});
    put_reg(CfgCleanTime, c.clean_ms);
    cfg_we <= 1'b0;
    tracker.cfg = c;
    settings_used++;
  endtask

  function automatic calib_cfg_t typical_cfg();
    calib_cfg_t c;
    c.plausible_max = PpmW'($urandom_range(1000, 3000));
    c.startup_reads = CountW'($urandom_range(0, 10));
    c.above_level   = PpmW'($urandom_range(300, 600));
    c.below_level   = PpmW'($urandom_range(350, 800));
    c.quiet_ms      = $urandom_range(0, 1500000);
    c.drop_step     = DiffW'(-$signed($urandom_range(0, 40)));
    c.big_drop      = DiffW'(-$signed($urandom_range(100, 800)));
    c.clean_ms      = $urandom_range(0, 2000000);
    return c;
  endfunction

  task automatic run_mix(input int unsigned count);
    int unsigned sent, len, hi, lo;
    int lvl;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 24) == 0) wait_drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 8: begin
          lvl = $urandom_range(3000, 4500);
          len = $urandom_range(32, 44);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) send_item('0, tick());
            else send_item(PpmW'(lvl), tick());
            lvl = lvl - $urandom_range(16, 60);
            if ($urandom_range(0, 9) == 0) lvl = lvl + $urandom_range(0, 500);
          end
        end
        4, 5: begin
          hi  = (tracker.cfg.above_level == 0) ? 1 : tracker.cfg.above_level;
          lo  = (hi > 200) ? hi - 200 : 1;
          len = $urandom_range(8, 24);
          for (int k = 0; k < len; k++) send_item(PpmW'($urandom_range(lo, hi)), tick());
        end
        6: begin
          lvl = $urandom_range(250, 450);
          len = $urandom_range(8, 20);
          for (int k = 0; k < len; k++) begin
            send_item(PpmW'(lvl), tick());
            lvl = lvl + $urandom_range(5, 50);
          end
        end
        7: begin
          len = $urandom_range(4, 12);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) send_item('0, $urandom);
            else send_item(PpmW'($urandom_range(0, 65535)), $urandom);
          end
        end
        default: begin
          hi  = (tracker.cfg.below_level > 1) ? tracker.cfg.below_level - 1 : 1;
          len = $urandom_range(6, 16);
          for (int k = 0; k < len; k++) send_item(PpmW'($urandom_range(1, hi)), tick());
        end
      endcase
      sent += len;
    end
  endtask

  initial begin
    calib_cfg_t c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start-up screening, level edges and timestamp wrap under reset values.
    send_item(16'd0, 32'd0);
    send_item(16'hFFFF, 32'hFFFF_FFFF);
    send_item(16'd1401, 32'd1000);
    send_item(16'd1400, 32'd2000);
    send_item(16'hFFFF, 32'd3000);
    send_item(16'd1, 32'd4000);
    send_item(16'd400, 32'd5000);
    send_item(16'd401, 32'd6000);
    send_item(16'd500, 32'd7000);
    send_item(16'd499, 32'd8000);
    send_item(16'd0, 32'd9000);
    send_item(16'd380, 32'hFFFF_FFF0);
    send_item(16'd390, 32'd700000);
    send_item(16'd2000, 32'd800000);
    send_item(16'd1950, 32'd900000);
    send_item(16'd1900, 32'd20000000);
    send_item(16'd1850, 32'd20010000);
    send_item(16'd1800, 32'd20020000);
    send_item(16'd1790, 32'd20030000);
    send_item(16'd1700, 32'd20040000);
    clock_ms = 32'd20040000;

    c.plausible_max = 16'hFFFF;
    c.startup_reads = 6'd63;
    c.above_level   = '0;
    c.below_level   = 16'hFFFF;
    c.quiet_ms      = '0;
    c.drop_step     = '0;
    c.big_drop      = '0;
    c.clean_ms      = '0;
    program_config(c);
    run_mix(110);

    c.plausible_max = '0;
    c.above_level   = 16'hFFFF;
    c.below_level   = '0;
    c.quiet_ms      = 32'hFFFF_FFFF;
    c.drop_step     = -17'sd65535;
    c.big_drop      = -17'sd65535;
    c.clean_ms      = 32'hFFFF_FFFF;
    program_config(c);
    run_mix(30);

    program_config(typical_cfg());
    run_mix(220);

    c.startup_reads = '0;
    c.clean_ms      = '0;
    program_config(c);
    run_mix(80);

    c = typical_cfg();
    c.startup_reads = 6'd63;
    c.plausible_max = PpmW'($urandom_range(2000, 4000));
    program_config(c);
    run_mix(200);

    wait_drain();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d readings over %0d register settings; %0d results checked.",
             items_sent, settings_used, tracker.results_seen);
    $display("Of these %0d were stored, with %0d quiet and %0d drop calibration requests.",
             tracker.stored, tracker.quiet_hits, tracker.drop_hits);
    if (tracker.faults == 0 && tracker.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d results still expected", tracker.faults,
               tracker.awaited.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
